FILE: rtl/queue_remove_at_position_top_assert.svh
// Assertion macros shared by the queue removal block.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef QUEUE_REMOVE_AT_POSITION_TOP_ASSERT_SVH
`define QUEUE_REMOVE_AT_POSITION_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QRAP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QRAP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/qrap_pkg.sv
// Shared types and codes for the queue removal block.
// Depends on nothing; used by qrap_mem, qrap_seq and the top level.
package qrap_pkg;

	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_FRONT = 2'd1;
	localparam logic [1:0] REQ_BACK  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TAKE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} seq_state_t;

	// Memory port strobes from the sequencer.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

FILE: rtl/qrap_mem.sv
// Word store of the queue: one write port and one registered read port.
// Depends on qrap_pkg for the port strobe struct.
module qrap_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                clk,
	input  qrap_pkg::mem_ctl_t  ctl,
	input  logic [AW-1:0]       waddr,
	input  logic signed [31:0]  wdata,
	input  logic [AW-1:0]       raddr,
	output logic signed [31:0]  rdata
);
	import qrap_pkg::*;

	logic signed [31:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/qrap_seq.sv
// Sequencer of the queue: request decode, entry count, and the one-slot-per-step
// close-up loop that reuses a single index incrementer. Depends on qrap_pkg and
// the assertion macro header.
`include "queue_remove_at_position_top_assert.svh"

module qrap_seq #(
	parameter int QUEUE_DEPTH = 16,
	parameter int AW          = 4,
	parameter int CW          = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          req_type,
	input  logic signed [31:0]  push_value,
	input  logic [CW-1:0]       position,
	output logic                done,
	output logic signed [31:0]  removed_value,
	output logic [1:0]          status,
	output logic [CW-1:0]       occupancy,
	output qrap_pkg::mem_ctl_t  ctl,
	output logic [AW-1:0]       waddr,
	output logic signed [31:0]  wdata,
	output logic [AW-1:0]       raddr,
	input  logic signed [31:0]  rdata
);
	import qrap_pkg::*;

	localparam int IW = AW + 1;

	seq_state_t state_q, state_d;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	logic signed [31:0] removed_q;
	logic [1:0]         status_q;

	logic          accept;
	logic          is_push;
	logic          is_remove;
	logic          full;
	logic          bad_pos;
	logic [AW-1:0] take_idx;
	logic [IW-1:0] idx_nxt;
	logic          more;

	always_comb begin
		accept    = start && (state_q == S_IDLE);
		is_push   = (req_type == REQ_PUSH);
		is_remove = (req_type == REQ_FRONT) || (req_type == REQ_BACK);
		full      = (count_q == CW'(QUEUE_DEPTH));
		bad_pos   = (position == '0) || (position > count_q);
		take_idx  = (req_type == REQ_FRONT) ? AW'(position - CW'(1)) : AW'(count_q - position);
		// The shared incrementer: next slot to pull forward, and whether it exists.
		idx_nxt   = IW'(idx_q) + IW'(1);
		more      = (idx_nxt < IW'(count_q));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (is_remove && !bad_pos) ? S_TAKE : S_DONE;
				end
			end
			S_TAKE:     state_d = S_SHIFT_RD;
			S_SHIFT_RD: state_d = more ? S_SHIFT_WR : S_DONE;
			S_SHIFT_WR: state_d = S_SHIFT_RD;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl   = '0;
		waddr = idx_q;
		wdata = rdata;
		raddr = idx_nxt[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept && is_push && !full) begin
					ctl.wr_en = 1'b1;
					waddr     = count_q[AW-1:0];
					wdata     = push_value;
				end
				if (accept && is_remove && !bad_pos) begin
					ctl.rd_en = 1'b1;
					raddr     = take_idx;
				end
			end
			S_SHIFT_RD: ctl.rd_en = more;
			S_SHIFT_WR: ctl.wr_en = 1'b1;
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && is_push && !full) begin
				count_q <= count_q + CW'(1);
			end else if ((state_q == S_SHIFT_RD) && !more) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q <= '0;
			idx_q     <= take_idx;
			if (is_push && full) begin
				status_q <= ST_FULL;
			end else if (is_remove && bad_pos) begin
				status_q <= ST_BADPOS;
			end else begin
				status_q <= ST_OK;
			end
		end else if (state_q == S_TAKE) begin
			removed_q <= rdata;
		end else if (state_q == S_SHIFT_WR) begin
			idx_q <= idx_nxt[AW-1:0];
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = (state_q == S_DONE);
	assign removed_value = removed_q;
	assign status        = status_q;
	assign occupancy     = count_q;

	`QRAP_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(QUEUE_DEPTH), "entry count above depth")
	`QRAP_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for more than one cycle")
	`QRAP_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
	`QRAP_ASSERT_NOW(a_shift_in_range, state_q == S_SHIFT_WR, IW'(idx_q) + IW'(1) < IW'(count_q),
		"close-up write past the last held entry")

endmodule

FILE: rtl/queue_remove_at_position_top.sv
// Queue with removal at a position counted from the front or the back.
// A push, a rejected request or an unused code passes through the done state back to idle,
// the result strobe following in the cycle after accept. A removal captures the taken word,
// then the close-up loop moves one entry per read and write state pair: a registered
// read of the next slot and then its write one slot forward. Reset (arst_n low) empties the
// queue and returns to idle at once. The result strobe lasts one cycle and cannot be held off.
module queue_remove_at_position_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [1:0]                             req_type,
	input  logic signed [31:0]                     push_value,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]       position,
	output logic                                   done,
	output logic signed [31:0]                     removed_value,
	output logic [1:0]                             status,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]       occupancy
);
	import qrap_pkg::*;

	// AW indexes the word store; CW holds a count from zero up to the full depth.
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	mem_ctl_t           mem_ctl;
	logic [AW-1:0]      mem_waddr;
	logic signed [31:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic signed [31:0] mem_rdata;

	// The sequencer decodes each request word, keeps the entry count, and walks
	// the store one slot at a time to close the gap left by a removed word.
	qrap_seq #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.AW          (AW),
		.CW          (CW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.push_value    (push_value),
		.position      (position),
		.done          (done),
		.removed_value (removed_value),
		.status        (status),
		.occupancy     (occupancy),
		.ctl           (mem_ctl),
		.waddr         (mem_waddr),
		.wdata         (mem_wdata),
		.raddr         (mem_raddr),
		.rdata         (mem_rdata)
	);

	// The word store holds the queue front at slot zero; only slots below the
	// count are ever read, so it needs no clearing after reset.
	qrap_mem #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
